### rtl/core/trd_pkg.sv
// Shared constants, register indexes and control types of the trilinear distance block.
package trd_pkg;

  localparam int unsigned GRAD_BITS        = 35;
  localparam int unsigned SCALE_BITS       = 8;
  localparam int unsigned INV_RES_BITS     = 16;
  localparam int unsigned UNK_DIST_BITS    = 24;
  localparam int unsigned CFG_DATA_BITS    = 24;
  localparam int unsigned OUTSIDE_BITS     = 10;
  localparam int unsigned OUT_DEPTH        = 16;

  localparam logic [INV_RES_BITS-1:0]  INV_RES_RESET  = 16'd2560;
  localparam logic [UNK_DIST_BITS-1:0] UNK_DIST_RESET = 24'd2560000;

  // -1.0 in Q.8
  localparam logic signed [OUTSIDE_BITS-1:0] OUTSIDE_DISTANCE = -10'sd256;

  typedef enum logic [0:0] {
    CFG_INV_RES  = 1'b0,
    CFG_UNK_DIST = 1'b1
  } trd_cfg_index_e;

  typedef struct packed {
    logic valid;
    logic in_map;
  } trd_ctrl_t;

endpackage

### rtl/core/trd_lerp.sv
// One interpolation lane: y = a + round(f * (b - a) / 2^F), three register stages.
module trd_lerp #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned ValBits  = 25
) (
  input  logic                       clk_i,
  input  logic signed [ValBits-1:0]  a_i,
  input  logic signed [ValBits-1:0]  b_i,
  input  logic        [FracBits-1:0] f_i,
  output logic signed [ValBits-1:0]  y_o
);

  localparam int unsigned ProdBits = FracBits + ValBits + 2;
  localparam logic signed [ProdBits-1:0] Half =
    {{(ProdBits-FracBits){1'b0}}, 1'b1, {(FracBits-1){1'b0}}};

  logic signed [ValBits-1:0]  a1_q, a2_q, y_q, y_d;
  logic signed [ValBits:0]    diff_q;
  logic        [FracBits-1:0] f1_q;
  logic signed [FracBits:0]   f_s;
  logic signed [ProdBits-1:0] prod_q, prod_d, rnd, shifted;

  assign f_s    = {1'b0, f1_q};
  assign prod_d = f_s * diff_q;

  // round to nearest, ties upward: floor((p + half) / 2^F)
  assign rnd     = prod_q + Half;
  assign shifted = rnd >>> FracBits;
  assign y_d     = a2_q + $signed(shifted[ValBits-1:0]);

  always_ff @(posedge clk_i) begin
    a1_q   <= a_i;
    diff_q <= {b_i[ValBits-1], b_i} - {a_i[ValBits-1], a_i};
    f1_q   <= f_i;
    a2_q   <= a1_q;
    prod_q <= prod_d;
    y_q    <= y_d;
  end

  assign y_o = y_q;

endmodule

### rtl/core/trd_merge.sv
// Merge stage: scale and saturate the gradients, clamp the distance, apply the map flag.
module trd_merge #(
  parameter int unsigned DistBits = 25,
  parameter int unsigned ValBits  = 25
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  trd_pkg::trd_ctrl_t                      ctrl_i,
  input  logic        [trd_pkg::INV_RES_BITS-1:0] inv_res_i,
  input  logic signed [ValBits-1:0]               dist_i,
  input  logic signed [ValBits-1:0]               gx_i,
  input  logic signed [ValBits-1:0]               gy_i,
  input  logic signed [ValBits-1:0]               gz_i,
  output trd_pkg::trd_ctrl_t                      ctrl_o,
  output logic signed [DistBits-1:0]              dist_o,
  output logic signed [trd_pkg::GRAD_BITS-1:0]    gx_o,
  output logic signed [trd_pkg::GRAD_BITS-1:0]    gy_o,
  output logic signed [trd_pkg::GRAD_BITS-1:0]    gz_o
);

  import trd_pkg::*;

  localparam int unsigned ProdBits = ValBits + INV_RES_BITS + 1;
  localparam logic signed [ProdBits-1:0] RoundHalf =
    {{(ProdBits-SCALE_BITS){1'b0}}, 1'b1, {(SCALE_BITS-1){1'b0}}};
  localparam logic signed [ProdBits-1:0] GradMax =
    {{(ProdBits-GRAD_BITS+1){1'b0}}, {(GRAD_BITS-1){1'b1}}};
  localparam logic signed [ProdBits-1:0] GradMin =
    {{(ProdBits-GRAD_BITS+1){1'b1}}, {(GRAD_BITS-1){1'b0}}};
  localparam logic signed [ValBits-1:0] DistMax =
    {{(ValBits-DistBits+1){1'b0}}, {(DistBits-1){1'b1}}};

  function automatic logic signed [GRAD_BITS-1:0] sat_grad(
    input logic signed [ProdBits-1:0] p
  );
    logic signed [ProdBits-1:0] rnd;
    logic signed [ProdBits-1:0] sh;
    rnd = p + RoundHalf;
    sh  = rnd >>> SCALE_BITS;
    if (sh > GradMax) begin
      return GradMax[GRAD_BITS-1:0];
    end else if (sh < GradMin) begin
      return GradMin[GRAD_BITS-1:0];
    end
    return sh[GRAD_BITS-1:0];
  endfunction

  logic signed [INV_RES_BITS:0]  inv_s;
  logic signed [ProdBits-1:0]    px_q, py_q, pz_q;
  logic signed [DistBits-1:0]    dist1_q, dist1_d;
  trd_ctrl_t                     ctrl1_q, ctrl2_q;
  logic signed [DistBits-1:0]    dist2_q, dist2_d;
  logic signed [GRAD_BITS-1:0]   gx2_q, gy2_q, gz2_q, gx2_d, gy2_d, gz2_d;

  assign inv_s = {1'b0, inv_res_i};

  // hold the distance inside the signed output range
  always_comb begin
    if (dist_i > DistMax) begin
      dist1_d = DistMax[DistBits-1:0];
    end else begin
      dist1_d = dist_i[DistBits-1:0];
    end
  end

  always_comb begin
    if (ctrl1_q.in_map) begin
      dist2_d = dist1_q;
      gx2_d   = sat_grad(px_q);
      gy2_d   = sat_grad(py_q);
      gz2_d   = sat_grad(pz_q);
    end else begin
      dist2_d = {{(DistBits-OUTSIDE_BITS){OUTSIDE_DISTANCE[OUTSIDE_BITS-1]}},
                 OUTSIDE_DISTANCE};
      gx2_d   = '0;
      gy2_d   = '0;
      gz2_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
    end else begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= gx_i * inv_s;
    py_q    <= gy_i * inv_s;
    pz_q    <= gz_i * inv_s;
    dist1_q <= dist1_d;
    dist2_q <= dist2_d;
    gx2_q   <= gx2_d;
    gy2_q   <= gy2_d;
    gz2_q   <= gz2_d;
  end

  assign ctrl_o = ctrl2_q;
  assign dist_o = dist2_q;
  assign gx_o   = gx2_q;
  assign gy_o   = gy2_q;
  assign gz_o   = gz2_q;

endmodule

### rtl/core/trd_fifo.sv
// Result queue between the free-running pipeline and the output channel.
module trd_fifo #(
  parameter int unsigned Width = 130,
  parameter int unsigned Depth = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int unsigned PtrBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [Width-1:0]   out_data_q;
  logic               out_vld_q;
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q;
  logic               rd_fire, out_free, mem_rd, mem_wr, bypass;

  function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
    if (p == PtrBits'(Depth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // refill the output register from storage, or straight from the write side when empty
  assign rd_fire  = out_vld_q && rd_ready_i;
  assign out_free = !out_vld_q || rd_fire;
  assign mem_rd   = out_free && (cnt_q != '0);
  assign bypass   = out_free && (cnt_q == '0) && wr_valid_i;
  assign mem_wr   = wr_valid_i && !bypass;

  assign rd_valid_o = out_vld_q;
  assign rd_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (mem_wr) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (mem_rd) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (mem_wr && !mem_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (mem_rd && !mem_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (out_free) begin
        out_vld_q <= mem_rd || bypass;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
    if (mem_rd) begin
      out_data_q <= mem_q[rd_ptr_q];
    end else if (bypass) begin
      out_data_q <= wr_data_i;
    end
  end

endmodule

### rtl/core/trilinear_distance_gradient.sv
// Top level: trilinear distance interpolation with analytic gradient over parallel lanes.
//
//   channel   dir  handshake                     content
//   s_axis    in   s_axis_tvalid/s_axis_tready   fractions, eight corners; tuser = in_map
//   m_axis    out  m_axis_tvalid/m_axis_tready   distance, grad_x, grad_y, grad_z
//   cfg       in   cfg_valid_i/cfg_ready_o       register index and write data
//
// One transaction is taken every cycle while s_axis_tready is high. Eleven
// interpolation lanes run side by side (x, then y, then z, for the distance and the
// three gradient terms), each a three-stage multiply lane; the longest lane chain
// plus the input register and the two-stage merge make twelve register stages.
// The pipeline never stalls; a sixteen-entry result queue absorbs output back-pressure
// and s_axis_tready drops only when sixteen transactions are in flight or queued.
// Reset clears the valid pipeline, the queue and the in-flight count, and loads the
// configuration registers with their defaults; no clearing pass follows.
module trilinear_distance_gradient #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned DISTANCE_BITS = 25
) (
  input  logic clk_i,
  input  logic rst_ni,

  // s_axis_tdata, lowest bit up: frac_x, frac_y, frac_z, corner_000, corner_001,
  // corner_010, corner_011, corner_100, corner_101, corner_110, corner_111, zero fill
  input  logic                                                   s_axis_tvalid,
  output logic                                                   s_axis_tready,
  input  logic [((3*FRACTION_BITS + 8*DISTANCE_BITS + 7)/8)*8-1:0] s_axis_tdata,
  // s_axis_tuser: in_map
  input  logic [0:0]                                             s_axis_tuser,

  // m_axis_tdata, lowest bit up: distance, grad_x, grad_y, grad_z, zero fill
  output logic                                                   m_axis_tvalid,
  input  logic                                                   m_axis_tready,
  output logic [((DISTANCE_BITS + 3*trd_pkg::GRAD_BITS + 7)/8)*8-1:0] m_axis_tdata,

  input  logic                                                   cfg_valid_i,
  output logic                                                   cfg_ready_o,
  input  trd_pkg::trd_cfg_index_e                                cfg_index_i,
  input  logic [trd_pkg::CFG_DATA_BITS-1:0]                      cfg_data_i
);

  import trd_pkg::*;

  localparam int unsigned OUT_DATA_BITS = ((DISTANCE_BITS + 3*GRAD_BITS + 7)/8)*8;
  localparam int unsigned RESULT_BITS   = DISTANCE_BITS + 3*GRAD_BITS;
  // corners are never negative after substitution; one extra bit keeps them signed
  localparam int unsigned VAL_BITS =
    ((DISTANCE_BITS - 1 > UNK_DIST_BITS) ? DISTANCE_BITS - 1 : UNK_DIST_BITS) + 1;
  localparam int unsigned PIPE_STAGES = 10;
  localparam int unsigned USED_BITS   = $clog2(OUT_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [INV_RES_BITS-1:0]  inv_res_q;
  logic [UNK_DIST_BITS-1:0] unk_dist_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_res_q  <= INV_RES_RESET;
      unk_dist_q <= UNK_DIST_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INV_RES:  inv_res_q  <= cfg_data_i[INV_RES_BITS-1:0];
        CFG_UNK_DIST: unk_dist_q <= cfg_data_i[UNK_DIST_BITS-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: count transactions accepted but not yet delivered, so the
  // free-running pipeline can always drain into the result queue.
  // ---------------------------------------------------------------------------
  logic                 in_fire, out_fire;
  logic [USED_BITS-1:0] used_q;

  assign s_axis_tready = (used_q < USED_BITS'(OUT_DEPTH));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (in_fire && !out_fire) begin
      used_q <= used_q + 1'b1;
    end else if (out_fire && !in_fire) begin
      used_q <= used_q - 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: unpack, substitute unknown corners (sign bit set)
  // ---------------------------------------------------------------------------
  logic        [DISTANCE_BITS-1:0] corner_raw [8];
  logic signed [VAL_BITS-1:0]      c_d [8];
  logic signed [VAL_BITS-1:0]      c_q [8];
  logic        [FRACTION_BITS-1:0] fx_q;
  logic        [FRACTION_BITS-1:0] fy_q [4];
  logic        [FRACTION_BITS-1:0] fz_q [7];
  logic                            map_q [PIPE_STAGES];
  logic                            vld_q [PIPE_STAGES];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      corner_raw[k] = s_axis_tdata[3*FRACTION_BITS + k*DISTANCE_BITS +: DISTANCE_BITS];
      if (corner_raw[k][DISTANCE_BITS-1]) begin
        c_d[k] = {{(VAL_BITS-UNK_DIST_BITS){1'b0}}, unk_dist_q};
      end else begin
        c_d[k] = {{(VAL_BITS-DISTANCE_BITS+1){1'b0}}, corner_raw[k][DISTANCE_BITS-2:0]};
      end
    end
  end

  // valid pipeline advances every cycle; payload taps follow it without reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= in_fire;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 8; k++) begin
      c_q[k] <= c_d[k];
    end
    fx_q     <= s_axis_tdata[FRACTION_BITS-1:0];
    fy_q[0]  <= s_axis_tdata[FRACTION_BITS +: FRACTION_BITS];
    fz_q[0]  <= s_axis_tdata[2*FRACTION_BITS +: FRACTION_BITS];
    map_q[0] <= s_axis_tuser[0];
    for (int k = 1; k < 4; k++) begin
      fy_q[k] <= fy_q[k-1];
    end
    for (int k = 1; k < 7; k++) begin
      fz_q[k] <= fz_q[k-1];
    end
    for (int k = 1; k < PIPE_STAGES; k++) begin
      map_q[k] <= map_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Lanes. Stage numbers count register edges after the input transaction.
  // ---------------------------------------------------------------------------
  logic signed [VAL_BITS-1:0] vx [4];      // x-lerps v00 v01 v10 v11, stage 4
  logic signed [VAL_BITS-1:0] dx_q [4];    // corner x-differences, stage 2
  logic signed [VAL_BITS-1:0] gxy [2];     // y-lerps of x-differences, stage 5
  logic signed [VAL_BITS-1:0] vy [2];      // y-lerps v0 v1, stage 7
  logic signed [VAL_BITS-1:0] dy_q [2];    // v10 - v00, v11 - v01, stage 5
  logic signed [VAL_BITS-1:0] gx_lane, gy_lane, dist_lane;
  logic signed [VAL_BITS-1:0] gz_q;        // v1 - v0, stage 8
  logic signed [VAL_BITS-1:0] gx_dly_q [2];
  logic signed [VAL_BITS-1:0] gy_dly_q [2];
  logic signed [VAL_BITS-1:0] gz_dly_q [2];

  for (genvar k = 0; k < 4; k++) begin : g_lane_x
    trd_lerp #(
      .FracBits(FRACTION_BITS),
      .ValBits (VAL_BITS)
    ) u_lerp (
      .clk_i(clk_i),
      .a_i  (c_q[k]),
      .b_i  (c_q[k+4]),
      .f_i  (fx_q),
      .y_o  (vx[k])
    );
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      dx_q[k] <= c_q[k+4] - c_q[k];
    end
    dy_q[0]     <= vx[2] - vx[0];
    dy_q[1]     <= vx[3] - vx[1];
    gz_q        <= vy[1] - vy[0];
    // align the gradient terms with the distance lane
    gx_dly_q[0] <= gx_lane;
    gx_dly_q[1] <= gx_dly_q[0];
    gy_dly_q[0] <= gy_lane;
    gy_dly_q[1] <= gy_dly_q[0];
    gz_dly_q[0] <= gz_q;
    gz_dly_q[1] <= gz_dly_q[0];
  end

  for (genvar k = 0; k < 2; k++) begin : g_lane_y
    trd_lerp #(
      .FracBits(FRACTION_BITS),
      .ValBits (VAL_BITS)
    ) u_lerp_d (
      .clk_i(clk_i),
      .a_i  (dx_q[k]),
      .b_i  (dx_q[k+2]),
      .f_i  (fy_q[1]),
      .y_o  (gxy[k])
    );

    trd_lerp #(
      .FracBits(FRACTION_BITS),
      .ValBits (VAL_BITS)
    ) u_lerp_v (
      .clk_i(clk_i),
      .a_i  (vx[k]),
      .b_i  (vx[k+2]),
      .f_i  (fy_q[3]),
      .y_o  (vy[k])
    );
  end

  trd_lerp #(
    .FracBits(FRACTION_BITS),
    .ValBits (VAL_BITS)
  ) u_lane_gx (
    .clk_i(clk_i),
    .a_i  (gxy[0]),
    .b_i  (gxy[1]),
    .f_i  (fz_q[4]),
    .y_o  (gx_lane)
  );

  trd_lerp #(
    .FracBits(FRACTION_BITS),
    .ValBits (VAL_BITS)
  ) u_lane_gy (
    .clk_i(clk_i),
    .a_i  (dy_q[0]),
    .b_i  (dy_q[1]),
    .f_i  (fz_q[4]),
    .y_o  (gy_lane)
  );

  trd_lerp #(
    .FracBits(FRACTION_BITS),
    .ValBits (VAL_BITS)
  ) u_lane_dist (
    .clk_i(clk_i),
    .a_i  (vy[0]),
    .b_i  (vy[1]),
    .f_i  (fz_q[6]),
    .y_o  (dist_lane)
  );

  // ---------------------------------------------------------------------------
  // Merge and result queue
  // ---------------------------------------------------------------------------
  trd_ctrl_t                     merge_ctrl_in, merge_ctrl_out;
  logic signed [DISTANCE_BITS-1:0] res_dist;
  logic signed [GRAD_BITS-1:0]     res_gx, res_gy, res_gz;
  logic [RESULT_BITS-1:0]          fifo_rd_data;

  assign merge_ctrl_in.valid  = vld_q[PIPE_STAGES-1];
  assign merge_ctrl_in.in_map = map_q[PIPE_STAGES-1];

  trd_merge #(
    .DistBits(DISTANCE_BITS),
    .ValBits (VAL_BITS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (merge_ctrl_in),
    .inv_res_i(inv_res_q),
    .dist_i   (dist_lane),
    .gx_i     (gx_dly_q[1]),
    .gy_i     (gy_dly_q[1]),
    .gz_i     (gz_dly_q[1]),
    .ctrl_o   (merge_ctrl_out),
    .dist_o   (res_dist),
    .gx_o     (res_gx),
    .gy_o     (res_gy),
    .gz_o     (res_gz)
  );

  trd_fifo #(
    .Width(RESULT_BITS),
    .Depth(OUT_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(merge_ctrl_out.valid),
    .wr_data_i ({res_gz, res_gy, res_gx, res_dist}),
    .rd_valid_o(m_axis_tvalid),
    .rd_ready_i(m_axis_tready),
    .rd_data_o (fifo_rd_data)
  );

  // zero fill to whole bytes
  assign m_axis_tdata = OUT_DATA_BITS'(fifo_rd_data);

endmodule
